// ----- sv/ftr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fitness ranker package
// Shared widths, constants and the structs passed between the ranker modules.
// ----------------------------------------------------------------------------
package ftr_pkg;

  localparam int ScoreW   = 24;
  localparam int TimeW    = 16;
  localparam int IndexW   = 4;
  localparam int TotalW   = 28;
  localparam int HalvesW  = 8;

  // Generation size; the average is the total shifted by floor(log2) of it.
  localparam int Population = 16;
  localparam int AvgShift   = $clog2(Population + 1) - 1;

  // A new record needs the best score to move by at least 1.0 in Q16.8.
  localparam int RecordStep = 256;

  localparam logic [HalvesW-1:0] MaxHalvesReset = 8'd20;

  typedef logic signed [ScoreW-1:0] score_t;
  typedef logic [TimeW-1:0]         time_t;
  typedef logic [IndexW-1:0]        index_t;
  typedef logic signed [TotalW-1:0] total_t;
  typedef logic [HalvesW-1:0]       halves_t;

  typedef struct packed {
    score_t score;
    time_t  elapsed_time;
    logic   last;
  } item_t;

  typedef struct packed {
    index_t  best_index;
    index_t  second_index;
    score_t  best_score;
    score_t  average_score;
    logic    new_record;
    halves_t mutation_halves;
  } result_t;

endpackage

// ----- sv/ftr_rank_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fitness ranker core
// Holds the best and second-best individuals, the score total and the
// mutation rate, and forms the generation summary on the last item.
// ----------------------------------------------------------------------------
module ftr_rank_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  ftr_pkg::item_t   item,
  input  ftr_pkg::halves_t max_halves,
  output ftr_pkg::result_t result
);
  import ftr_pkg::*;

  index_t  count_r,        count_nxt;
  index_t  top_index_r,    top_index_nxt;
  score_t  top_score_r,    top_score_nxt;
  time_t   top_time_r,     top_time_nxt;
  index_t  run_index_r,    run_index_nxt;
  score_t  run_score_r,    run_score_nxt;
  time_t   run_time_r,     run_time_nxt;
  total_t  total_r,        total_nxt;
  score_t  prev_best_r,    prev_best_nxt;
  halves_t rate_r,         rate_nxt;

  logic                      beats_top;
  logic                      beats_run;
  total_t                    avg_wide;
  logic signed [ScoreW:0]    diff;
  logic                      record;
  halves_t                   rate_new;
  score_t                    avg_sat;

  // Higher score wins; an equal score goes to the lower-or-equal time.
  assign beats_top = (item.score > top_score_r) ||
                     ((item.score == top_score_r) && (item.elapsed_time <= top_time_r));
  assign beats_run = (item.score > run_score_r) ||
                     ((item.score == run_score_r) && (item.elapsed_time <= run_time_r));

  always_comb begin
    top_index_nxt = top_index_r;
    top_score_nxt = top_score_r;
    top_time_nxt  = top_time_r;
    run_index_nxt = run_index_r;
    run_score_nxt = run_score_r;
    run_time_nxt  = run_time_r;
    if (count_r == '0) begin
      top_index_nxt = count_r;
      top_score_nxt = item.score;
      top_time_nxt  = item.elapsed_time;
      run_index_nxt = count_r;
      run_score_nxt = item.score;
      run_time_nxt  = item.elapsed_time;
      total_nxt     = TotalW'(item.score);
    end else begin
      total_nxt = total_r + TotalW'(item.score);
      if (beats_top) begin
        run_index_nxt = top_index_r;
        run_score_nxt = top_score_r;
        run_time_nxt  = top_time_r;
        top_index_nxt = count_r;
        top_score_nxt = item.score;
        top_time_nxt  = item.elapsed_time;
      end else if ((count_r == IndexW'(1)) || beats_run) begin
        run_index_nxt = count_r;
        run_score_nxt = item.score;
        run_time_nxt  = item.elapsed_time;
      end
    end
  end

  // Summary, valid when the current item is the last of its generation.
  always_comb begin
    avg_wide = total_nxt >>> AvgShift;
    if ((avg_wide[TotalW-1:ScoreW-1] == '0) || (avg_wide[TotalW-1:ScoreW-1] == '1)) begin
      avg_sat = avg_wide[ScoreW-1:0];
    end else if (avg_wide[TotalW-1]) begin
      avg_sat = {1'b1, {(ScoreW-1){1'b0}}};
    end else begin
      avg_sat = {1'b0, {(ScoreW-1){1'b1}}};
    end
    diff   = (ScoreW+1)'(top_score_nxt) - (ScoreW+1)'(prev_best_r);
    record = (diff >= (ScoreW+1)'(RecordStep)) || (diff <= -(ScoreW+1)'(RecordStep));
    if (record) begin
      rate_new = '0;
    end else if (rate_r < max_halves) begin
      rate_new = rate_r + 1'b1;
    end else begin
      rate_new = rate_r;
    end
  end

  always_comb begin
    count_nxt     = count_r;
    prev_best_nxt = prev_best_r;
    rate_nxt      = rate_r;
    if (step) begin
      if (item.last) begin
        count_nxt     = '0;
        prev_best_nxt = top_score_nxt;
        rate_nxt      = rate_new;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  assign result.best_index      = top_index_nxt;
  assign result.second_index    = run_index_nxt;
  assign result.best_score      = top_score_nxt;
  assign result.average_score   = avg_sat;
  assign result.new_record      = record;
  assign result.mutation_halves = rate_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      top_index_r <= '0;
      top_score_r <= '0;
      top_time_r  <= '0;
      run_index_r <= '0;
      run_score_r <= '0;
      run_time_r  <= '0;
      total_r     <= '0;
      prev_best_r <= '0;
      rate_r      <= '0;
    end else begin
      count_r     <= count_nxt;
      prev_best_r <= prev_best_nxt;
      rate_r      <= rate_nxt;
      if (step) begin
        top_index_r <= top_index_nxt;
        top_score_r <= top_score_nxt;
        top_time_r  <= top_time_nxt;
        run_index_r <= run_index_nxt;
        run_score_r <= run_score_nxt;
        run_time_r  <= run_time_nxt;
        total_r     <= total_nxt;
      end
    end
  end

endmodule

// ----- sv/fitness_top_two_ranker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-two fitness ranker
// Ranks a generation's individuals and reports the best two, the average
// score, a new-record flag and an adaptive mutation rate.
// ----------------------------------------------------------------------------
// Individuals enter on the in_ channel, one transfer each, in population
// order; in_last marks the final individual of a generation. Each transfer is
// first captured in an input register. When it moves on, the core compares it
// with the stored best and second best, adds it to the running total and, on
// a last item, loads the generation summary into the output register. A
// summary is therefore offered on out_valid once the last item has left the
// input register and its summary is loaded into the free output register.
// Ranking and accumulation are a single compare-and-add step, so one item is
// taken per cycle while in_ready is high, which it is unless a last item waits.
// Items that are not last never wait on the result channel. When the receiver
// stalls with a summary pending, a further last item waits in the input
// register and in_ready falls until out_ready frees the output register.
// The cfg_ channel writes the mutation-rate limit in units of 0.5; it is
// always ready and takes effect for the next summary. Reset clears the
// ranking state, the mutation rate and the previous best, empties both
// registers and sets the limit to 20.
// ----------------------------------------------------------------------------
module fitness_top_two_ranker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ftr_pkg::score_t         in_score,
  input  ftr_pkg::time_t          in_elapsed_time,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ftr_pkg::index_t         out_best_index,
  output ftr_pkg::index_t         out_second_index,
  output ftr_pkg::score_t         out_best_score,
  output ftr_pkg::score_t         out_average_score,
  output logic                    out_new_record,
  output ftr_pkg::halves_t        out_mutation_halves,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  ftr_pkg::halves_t        cfg_max_mutation_halves
);
  import ftr_pkg::*;

  halves_t max_halves_r, max_halves_nxt;
  logic    s_valid_r,    s_valid_nxt;
  item_t   s_item_r;
  logic    out_valid_r,  out_valid_nxt;
  result_t out_r;
  result_t core_result;
  logic    s_advance;
  logic    in_take;

  // The configuration register is a plain write target.
  assign cfg_ready = 1'b1;

  always_comb begin
    max_halves_nxt = max_halves_r;
    if (cfg_valid) begin
      max_halves_nxt = cfg_max_mutation_halves;
    end
  end

  // The held item moves on unless it carries a summary and the output
  // register is still occupied by one the receiver has not taken.
  assign s_advance = s_valid_r && (!s_item_r.last || !out_valid_r || out_ready);
  assign in_ready  = !s_valid_r || s_advance;
  assign in_take   = in_valid && in_ready;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_take) begin
      s_valid_nxt = 1'b1;
    end else if (s_advance) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s_advance && s_item_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  ftr_rank_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s_advance),
    .item       (s_item_r),
    .max_halves (max_halves_r),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_halves_r <= MaxHalvesReset;
      s_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      max_halves_r <= max_halves_nxt;
      s_valid_r    <= s_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_item_r.score        <= in_score;
      s_item_r.elapsed_time <= in_elapsed_time;
      s_item_r.last         <= in_last;
    end
    if (s_advance && s_item_r.last) begin
      out_r <= core_result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_best_index      = out_r.best_index;
  assign out_second_index    = out_r.second_index;
  assign out_best_score      = out_r.best_score;
  assign out_average_score   = out_r.average_score;
  assign out_new_record      = out_r.new_record;
  assign out_mutation_halves = out_r.mutation_halves;

endmodule
